@@ sv/stream_substring_replace_defines.svh @@
// Assertion macros shared by the substring replacement RTL.
`ifndef STREAM_SUBSTRING_REPLACE_DEFINES_SVH
`define STREAM_SUBSTRING_REPLACE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define SSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ssr_pkg.sv @@
// Types, sizes and register codes of the substring replacement block.
`default_nettype none

package ssr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int MAX_REPLACE = 8;
  localparam int PAT_CAP     = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
  localparam int REP_CAP     = (MAX_REPLACE < 8) ? MAX_REPLACE : 8;
  localparam int JOB_DEPTH   = (PAT_CAP > REP_CAP) ? PAT_CAP : REP_CAP;
  localparam int FILL_W      = $clog2(PAT_CAP + 1);
  localparam int CNT_W       = $clog2(JOB_DEPTH + 1);
  localparam int IDX_W       = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 64;

  typedef enum logic [1:0] {
    REG_PATTERN_LEN   = 2'd0,
    REG_PATTERN_BYTES = 2'd1,
    REG_REPLACE_LEN   = 2'd2,
    REG_REPLACE_BYTES = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       string_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        char_present;
    logic        run_last;
    logic        string_done;
    logic [31:0] out_length;
    logic [31:0] match_total;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  pattern_len;
    logic [63:0] pattern_bytes;
    logic [3:0]  replace_len;
    logic [63:0] replace_bytes;
  } cfg_t;

  // Everything one item produces: characters, then an optional end marker.
  typedef struct packed {
    logic [JOB_DEPTH-1:0][7:0] chars;
    logic [CNT_W-1:0]          cnt;
    logic                      mark;
    logic [31:0]               len;
    logic [31:0]               match_cnt;
  } job_t;

endpackage

`default_nettype wire

@@ sv/stream_substring_replace.sv @@
// Top level of the streaming substring replacement block.
// Text enters one byte per item; each occurrence of the pattern (1 to 8 bytes,
// found left to right without overlap) is replaced by the replacement (0 to 8
// bytes), and the last byte of a string flushes the window and adds an end
// marker with the saturating output length and match count. An accepted item
// is turned combinationally into its full list of results and placed in a job
// register; the result register sends one result per cycle unless the output
// stalls, so an item with several results holds the input until its last
// result moves out, and items with zero or one result are taken every cycle
// unless the output stalls. The user must make configuration writes only
// while no item is in flight; the block itself does not enforce this.
`default_nettype none

module stream_substring_replace
  import ssr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output logic      [DATA_W-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t cfg;
  job_t job;
  logic fill_clear;
  logic in_fire;

  assign in_fire = in_valid && in_ready;

  ssr_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg),
    .fill_clear (fill_clear)
  );

  ssr_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_data),
    .in_fire   (in_fire),
    .cfg       (cfg),
    .fill_clear(fill_clear),
    .job       (job)
  );

  ssr_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_in   (job),
    .in_valid (in_valid),
    .job_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_data)
  );

endmodule

`default_nettype wire

@@ sv/ssr_cfg.sv @@
// Configuration register file with an APB-style write and read port.
`default_nettype none

module ssr_cfg
  import ssr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output logic      [DATA_W-1:0] cfg_prdata,
  output logic                   cfg_pready,
  output cfg_t                   cfg,
  output logic                   fill_clear
);

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign idx        = reg_idx_t'(cfg_paddr[ADDR_W-1:3]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;
  // A new pattern length drops whatever the window holds.
  assign fill_clear = wr_en && (idx == REG_PATTERN_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_len   <= 4'd1;
      cfg_r.pattern_bytes <= '0;
      cfg_r.replace_len   <= '0;
      cfg_r.replace_bytes <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_PATTERN_LEN:   cfg_r.pattern_len   <= cfg_pwdata[3:0];
        REG_PATTERN_BYTES: cfg_r.pattern_bytes <= cfg_pwdata;
        REG_REPLACE_LEN:   cfg_r.replace_len   <= cfg_pwdata[3:0];
        REG_REPLACE_BYTES: cfg_r.replace_bytes <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PATTERN_LEN:   cfg_prdata = {{(DATA_W-4){1'b0}}, cfg_r.pattern_len};
      REG_PATTERN_BYTES: cfg_prdata = cfg_r.pattern_bytes;
      REG_REPLACE_LEN:   cfg_prdata = {{(DATA_W-4){1'b0}}, cfg_r.replace_len};
      REG_REPLACE_BYTES: cfg_prdata = cfg_r.replace_bytes;
      default:           cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/ssr_step.sv @@
// Match window, string counters and the per-item result job.
`default_nettype none
`include "stream_substring_replace_defines.svh"

module ssr_step
  import ssr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t in_item,
  input  wire logic     in_fire,
  input  wire cfg_t     cfg,
  input  wire logic     fill_clear,
  output job_t          job
);

  logic [PAT_CAP-1:0][7:0] win_r, win_nxt, wnew;
  logic [FILL_W-1:0]       fill_r, fill_nxt, fill0, nfill, plen;
  logic [31:0]             len_r, len_nxt, match_r, match_nxt;
  logic [CNT_W-1:0]        rlen;
  logic                    full, hit;
  logic [32:0]             len_sum;

  always_comb begin
    if (cfg.pattern_len == 4'd0) begin
      plen = FILL_W'(1);
    end else if (cfg.pattern_len > 4'(PAT_CAP)) begin
      plen = FILL_W'(PAT_CAP);
    end else begin
      plen = FILL_W'(cfg.pattern_len);
    end
    if (cfg.replace_len > 4'(REP_CAP)) begin
      rlen = CNT_W'(REP_CAP);
    end else begin
      rlen = CNT_W'(cfg.replace_len);
    end

    fill0 = (fill_r >= plen) ? '0 : fill_r;
    for (int k = 0; k < PAT_CAP; k++) begin
      wnew[k] = (FILL_W'(k) == fill0) ? in_item.text_byte : win_r[k];
    end
    nfill = fill0 + 1'b1;
    full  = (nfill == plen);

    hit = full;
    for (int k = 0; k < PAT_CAP; k++) begin
      if ((FILL_W'(k) < plen) && (wnew[k] != cfg.pattern_bytes[8*k +: 8])) begin
        hit = 1'b0;
      end
    end

    // On a miss the window itself lists the bytes to send, oldest first.
    for (int k = 0; k < JOB_DEPTH; k++) begin
      job.chars[k] = 8'h00;
      if (hit) begin
        if (k < REP_CAP) job.chars[k] = cfg.replace_bytes[8*k +: 8];
      end else begin
        if (k < PAT_CAP) job.chars[k] = wnew[k];
      end
    end

    if (hit) begin
      job.cnt = rlen;
    end else if (full) begin
      job.cnt = in_item.string_end ? CNT_W'(plen) : CNT_W'(1);
    end else begin
      job.cnt = in_item.string_end ? CNT_W'(nfill) : '0;
    end
    job.mark = in_item.string_end;

    len_sum   = {1'b0, len_r} + 33'(job.cnt);
    len_nxt   = len_sum[32] ? '1 : len_sum[31:0];
    match_nxt = (hit && (match_r != '1)) ? match_r + 32'd1 : match_r;
    job.len       = len_nxt;
    job.match_cnt = match_nxt;

    win_nxt = wnew;
    if (in_item.string_end || hit) begin
      fill_nxt = '0;
    end else if (full) begin
      fill_nxt = plen - 1'b1;
      win_nxt  = wnew >> 8;
    end else begin
      fill_nxt = nfill;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      fill_r  <= '0;
      len_r   <= '0;
      match_r <= '0;
    end else if (fill_clear) begin
      fill_r <= '0;
    end else if (in_fire) begin
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      len_r   <= in_item.string_end ? '0 : len_nxt;
      match_r <= in_item.string_end ? '0 : match_nxt;
    end
  end

  `SSR_ASSERT_NEXT(a_end_clears, in_fire && in_item.string_end && !fill_clear, (fill_r == '0) && (len_r == '0) && (match_r == '0), "string end left state behind")

endmodule

`default_nettype wire

@@ sv/ssr_emit.sv @@
// Job register and result register: sends one result per cycle unless stalled.
`default_nettype none
`include "stream_substring_replace_defines.svh"

module ssr_emit
  import ssr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire job_t job_in,
  input  wire logic in_valid,
  output logic      job_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_item
);

  job_t             job_r;
  logic [CNT_W-1:0] idx_r;
  logic             out_valid_r;
  out_item_t        out_item_r, cur;
  logic             busy, cur_char, cur_last, out_take, load;

  assign cur_char  = (idx_r < job_r.cnt);
  assign busy      = cur_char || job_r.mark;
  assign cur_last  = cur_char ? ((idx_r + 1'b1 == job_r.cnt) && !job_r.mark) : 1'b1;
  assign out_take  = !out_valid_r || out_ready;
  // The next item may enter while the last result of this one moves out.
  assign job_ready = !busy || (out_take && cur_last);
  assign load      = in_valid && job_ready;

  always_comb begin
    cur.out_char     = cur_char ? job_r.chars[idx_r[IDX_W-1:0]] : 8'h00;
    cur.char_present = cur_char;
    cur.run_last     = cur_last;
    cur.string_done  = !cur_char;
    cur.out_length   = cur_char ? '0 : job_r.len;
    cur.match_total  = cur_char ? '0 : job_r.match_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_r <= '0;
      idx_r <= '0;
    end else if (load) begin
      job_r <= job_in;
      idx_r <= '0;
    end else if (busy && out_take) begin
      if (cur_char) begin
        idx_r <= idx_r + 1'b1;
      end else begin
        job_r.mark <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_item_r <= cur;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `SSR_ASSERT_NOW(a_idx_bound, 1'b1, idx_r <= job_r.cnt, "job index ran past its count")
  `SSR_ASSERT_NOW(a_marker_last, out_valid_r && !out_item_r.char_present, out_item_r.run_last && out_item_r.string_done, "end marker not closing its item")
  `SSR_ASSERT_NEXT(a_job_live, load && ((job_in.cnt != '0) || job_in.mark), busy, "loaded job with results went idle")

endmodule

`default_nettype wire
